// ===== sv/graph_degeneracy_ordering_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the degeneracy ordering core
// Each macro expands to one labelled concurrent assertion on clk_i/rst_ni.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DEGENERACY_ORDERING_CORE_MACROS_SVH
`define GRAPH_DEGENERACY_ORDERING_CORE_MACROS_SVH

// Property must hold at every edge out of reset.
`define GDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true out of reset.
`define GDO_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== sv/gdo_pkg.sv =====
// ----------------------------------------------------------------------------
// gdo_pkg
// Shared types and constants of the degeneracy ordering core.
// ----------------------------------------------------------------------------
package gdo_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned VAL_W   = 13;
  localparam int unsigned ERR_W   = 2;
  localparam logic [VAL_W-1:0] VALUE_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2
  } gdo_op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } gdo_err_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_W,
    ST_CLR,
    ST_DEG_E,
    ST_DEG_CHK,
    ST_DEG_AW,
    ST_DEG_BR,
    ST_DEG_BW,
    ST_SCAN,
    ST_PICK,
    ST_DEC_E,
    ST_DEC_CHK,
    ST_DEC_BW,
    ST_DEC_AR,
    ST_DEC_AW,
    ST_BK_CLR,
    ST_BK_E,
    ST_BK_CHK,
    ST_BK_LA,
    ST_BK_LB,
    ST_BK_WR,
    ST_DONE
  } gdo_state_e;

  // Command from the front end to the node engine.
  typedef struct packed {
    logic              compute;
    logic              read;
    logic [NODE_W-1:0] node;
  } gdo_cmd_t;

  // Completion from the node engine.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } gdo_rsp_t;

endpackage

// ===== sv/gdo_in_if.sv =====
// ----------------------------------------------------------------------------
// gdo_in_if
// Command channel: valid/ready with opcode and two node fields.
// ----------------------------------------------------------------------------
interface gdo_in_if;
  import gdo_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, output opcode, output first_node, output second_node,
                  input ready);
  modport sink   (input valid, input opcode, input first_node, input second_node,
                  output ready);
endinterface

// ===== sv/gdo_out_if.sv =====
// ----------------------------------------------------------------------------
// gdo_out_if
// Result channel: valid/ready with value and error code.
// ----------------------------------------------------------------------------
interface gdo_out_if;
  import gdo_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic [ERR_W-1:0] error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

// ===== sv/gdo_edge_store.sv =====
// ----------------------------------------------------------------------------
// gdo_edge_store
// Edge list memory with fill count; one write and one registered read.
// ----------------------------------------------------------------------------
module gdo_edge_store #(
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [gdo_pkg::NODE_W-1:0]             wr_a_i,
  input  logic [gdo_pkg::NODE_W-1:0]             wr_b_i,
  input  logic                                   clear_i,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr_i,
  output logic [gdo_pkg::NODE_W-1:0]             rd_a_o,
  output logic [gdo_pkg::NODE_W-1:0]             rd_b_o,
  output logic [$clog2(MAX_EDGES+1)-1:0]         count_o
);
  import gdo_pkg::*;

  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES+1);

  logic [2*NODE_W-1:0] mem [MAX_EDGES];
  logic [2*NODE_W-1:0] rd_q;
  logic [ECW-1:0]      count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (wr_en_i) begin
      count_d = count_q + ECW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[EAW'(count_q)] <= {wr_a_i, wr_b_i};
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_a_o  = rd_q[2*NODE_W-1:NODE_W];
  assign rd_b_o  = rd_q[NODE_W-1:0];
  assign count_o = count_q;
endmodule

// ===== sv/gdo_node_engine.sv =====
// ----------------------------------------------------------------------------
// gdo_node_engine
// Degree and label memories with the peeling sequencer.
// ----------------------------------------------------------------------------
module gdo_node_engine #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gdo_pkg::gdo_cmd_t                      cmd_i,
  input  logic [gdo_pkg::CFG_W-1:0]              n_i,
  output gdo_pkg::gdo_rsp_t                      rsp_o,
  output logic                                   edge_clear_o,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_ra_o,
  input  logic [gdo_pkg::NODE_W-1:0]             edge_a_i,
  input  logic [gdo_pkg::NODE_W-1:0]             edge_b_i,
  input  logic [$clog2(MAX_EDGES+1)-1:0]         edge_cnt_i
);
  import gdo_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned LW  = $clog2(MAX_NODES+1);
  localparam int unsigned DW  = $clog2(2*MAX_EDGES+1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES+1);

  gdo_state_e st_q, st_d;

  logic [CFG_W-1:0]  idx_q, idx_d, sidx_q, sidx_d, step_q, step_d;
  logic [CFG_W-1:0]  pick_q, pick_d, lab_n_q, lab_n_d;
  logic              sv_q, sv_d, found_q, found_d, rd_ok_q, rd_ok_d;
  logic [DW-1:0]     pdeg_q, pdeg_d, best_q, best_d;
  logic [ECW-1:0]    eidx_q, eidx_d;
  logic [NODE_W-1:0] ea_q, ea_d, eb_q, eb_d, tgt_q, tgt_d;
  logic [LW-1:0]     la_q, la_d;

  // node memories
  logic [DW-1:0] deg_mem [MAX_NODES];
  logic [LW-1:0] lab_mem [MAX_NODES];
  logic [DW-1:0] deg_rd_q;
  logic [LW-1:0] lab_rd_q;
  logic [NW-1:0] node_ra, node_wa;
  logic          deg_we, lab_we;
  logic [DW-1:0] deg_wd;
  logic [LW-1:0] lab_wd;

  logic e_ok, a_pick, b_pick, peel_end;
  logic [DW-1:0] deg_inc;

  assign e_ok    = (CFG_W'(edge_a_i) < n_i) && (CFG_W'(edge_b_i) < n_i);
  assign a_pick  = CFG_W'(edge_a_i) == pick_q;
  assign b_pick  = CFG_W'(edge_b_i) == pick_q;
  assign peel_end = (step_q + CFG_W'(1)) == n_i;
  assign deg_inc = deg_rd_q + DW'(1);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_i.compute) begin
          st_d = ST_CLR;
        end else if (cmd_i.read) begin
          st_d = ST_RD_W;
        end
      end
      ST_RD_W:    st_d = ST_IDLE;
      ST_CLR:     if (idx_q == n_i) st_d = ST_DEG_E;
      ST_DEG_E: begin
        if (eidx_q == edge_cnt_i) begin
          st_d = (step_q == n_i) ? ST_BK_CLR : ST_SCAN;
        end else begin
          st_d = ST_DEG_CHK;
        end
      end
      ST_DEG_CHK: st_d = e_ok ? ST_DEG_AW : ST_DEG_E;
      ST_DEG_AW:  st_d = ST_DEG_BR;
      ST_DEG_BR:  st_d = ST_DEG_BW;
      ST_DEG_BW:  st_d = ST_DEG_E;
      ST_SCAN:    if (idx_q == n_i && !sv_q) st_d = ST_PICK;
      ST_PICK:    st_d = ST_DEC_E;
      ST_DEC_E: begin
        if (eidx_q == edge_cnt_i) begin
          st_d = peel_end ? ST_BK_CLR : ST_SCAN;
        end else begin
          st_d = ST_DEC_CHK;
        end
      end
      ST_DEC_CHK: begin
        if (e_ok && a_pick) begin
          st_d = ST_DEC_BW;
        end else if (e_ok && b_pick) begin
          st_d = ST_DEC_AW;
        end else begin
          st_d = ST_DEC_E;
        end
      end
      ST_DEC_BW:  st_d = (CFG_W'(eb_q) == pick_q) ? ST_DEC_AR : ST_DEC_E;
      ST_DEC_AR:  st_d = ST_DEC_AW;
      ST_DEC_AW:  st_d = ST_DEC_E;
      ST_BK_CLR:  if (idx_q == n_i) st_d = ST_BK_E;
      ST_BK_E:    st_d = (eidx_q == edge_cnt_i) ? ST_DONE : ST_BK_CHK;
      ST_BK_CHK:  st_d = (e_ok && edge_a_i != edge_b_i) ? ST_BK_LA : ST_BK_E;
      ST_BK_LA:   st_d = ST_BK_LB;
      ST_BK_LB:   st_d = (lab_rd_q != la_q) ? ST_BK_WR : ST_BK_E;
      ST_BK_WR:   st_d = ST_BK_E;
      ST_DONE:    st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    idx_d   = idx_q;   sidx_d  = sidx_q;  step_d  = step_q;
    pick_d  = pick_q;  lab_n_d = lab_n_q; sv_d    = 1'b0;
    found_d = found_q; rd_ok_d = rd_ok_q; pdeg_d  = pdeg_q;
    best_d  = best_q;  eidx_d  = eidx_q;  ea_d    = ea_q;
    eb_d    = eb_q;    tgt_d   = tgt_q;   la_d    = la_q;
    node_ra = '0;      node_wa = '0;
    deg_we  = 1'b0;    lab_we  = 1'b0;
    deg_wd  = '0;      lab_wd  = '0;
    edge_ra_o    = EAW'(eidx_q);
    edge_clear_o = 1'b0;
    rsp_o        = '0;
    case (st_q)
      ST_IDLE: begin
        node_ra = NW'(cmd_i.node);
        rd_ok_d = CFG_W'(cmd_i.node) < lab_n_q;
        idx_d   = '0;
        step_d  = '0;
        eidx_d  = '0;
      end
      ST_RD_W: begin
        rsp_o.done  = 1'b1;
        rsp_o.value = rd_ok_q ? VAL_W'(lab_rd_q) : '0;
      end
      ST_CLR: begin
        if (idx_q != n_i) begin
          node_wa = NW'(idx_q);
          deg_we  = 1'b1;
          lab_we  = 1'b1;
          idx_d   = idx_q + CFG_W'(1);
        end else begin
          idx_d = '0;
        end
      end
      ST_DEG_E: begin
        found_d = 1'b0;
      end
      ST_DEG_CHK: begin
        ea_d    = edge_a_i;
        eb_d    = edge_b_i;
        node_ra = NW'(edge_a_i);
        if (!e_ok) eidx_d = eidx_q + ECW'(1);
      end
      ST_DEG_AW: begin
        node_wa = NW'(ea_q);
        deg_we  = 1'b1;
        deg_wd  = deg_inc;
      end
      ST_DEG_BR: begin
        node_ra = NW'(eb_q);
      end
      ST_DEG_BW: begin
        node_wa = NW'(eb_q);
        deg_we  = 1'b1;
        deg_wd  = deg_inc;
        eidx_d  = eidx_q + ECW'(1);
      end
      ST_SCAN: begin
        // issue one node a cycle, judge the one issued before
        node_ra = NW'(idx_q);
        if (idx_q != n_i) begin
          sv_d   = 1'b1;
          sidx_d = idx_q;
          idx_d  = idx_q + CFG_W'(1);
        end
        if (sv_q && lab_rd_q == '0 && (!found_q || deg_rd_q < pdeg_q)) begin
          pick_d  = sidx_q;
          pdeg_d  = deg_rd_q;
          found_d = 1'b1;
        end
      end
      ST_PICK: begin
        node_wa = NW'(pick_q);
        lab_we  = 1'b1;
        lab_wd  = LW'(n_i - step_q);
        eidx_d  = '0;
      end
      ST_DEC_E: begin
        if (eidx_q == edge_cnt_i) begin
          step_d  = step_q + CFG_W'(1);
          idx_d   = '0;
          found_d = 1'b0;
          eidx_d  = '0;
        end
      end
      ST_DEC_CHK: begin
        ea_d = edge_a_i;
        eb_d = edge_b_i;
        if (e_ok && a_pick) begin
          node_ra = NW'(edge_b_i);
        end else if (e_ok && b_pick) begin
          node_ra = NW'(edge_a_i);
        end else begin
          eidx_d = eidx_q + ECW'(1);
        end
      end
      ST_DEC_BW: begin
        node_wa = NW'(eb_q);
        deg_we  = (lab_rd_q == '0) && (deg_rd_q != '0);
        deg_wd  = deg_rd_q - DW'(1);
        if (CFG_W'(eb_q) != pick_q) eidx_d = eidx_q + ECW'(1);
      end
      ST_DEC_AR: begin
        node_ra = NW'(ea_q);
      end
      ST_DEC_AW: begin
        node_wa = NW'(ea_q);
        deg_we  = (lab_rd_q == '0) && (deg_rd_q != '0);
        deg_wd  = deg_rd_q - DW'(1);
        eidx_d  = eidx_q + ECW'(1);
      end
      ST_BK_CLR: begin
        best_d = '0;
        eidx_d = '0;
        if (idx_q != n_i) begin
          node_wa = NW'(idx_q);
          deg_we  = 1'b1;
          idx_d   = idx_q + CFG_W'(1);
        end
      end
      ST_BK_E: begin
        sv_d = 1'b0;
      end
      ST_BK_CHK: begin
        ea_d    = edge_a_i;
        eb_d    = edge_b_i;
        node_ra = NW'(edge_a_i);
        if (!(e_ok && edge_a_i != edge_b_i)) eidx_d = eidx_q + ECW'(1);
      end
      ST_BK_LA: begin
        la_d    = lab_rd_q;
        node_ra = NW'(eb_q);
      end
      ST_BK_LB: begin
        // the end with the larger label, picked earlier in the peel, gains a back edge
        if (lab_rd_q < la_q) begin
          tgt_d   = ea_q;
          node_ra = NW'(ea_q);
        end else if (la_q < lab_rd_q) begin
          tgt_d   = eb_q;
          node_ra = NW'(eb_q);
        end else begin
          eidx_d = eidx_q + ECW'(1);
        end
      end
      ST_BK_WR: begin
        node_wa = NW'(tgt_q);
        deg_we  = 1'b1;
        deg_wd  = deg_inc;
        if (deg_inc > best_q) best_d = deg_inc;
        eidx_d  = eidx_q + ECW'(1);
      end
      ST_DONE: begin
        rsp_o.done   = 1'b1;
        rsp_o.value  = (32'(best_q) > 32'(VALUE_MAX)) ? VALUE_MAX : VAL_W'(best_q);
        edge_clear_o = 1'b1;
        lab_n_d      = n_i;
      end
      default: begin
        sv_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      lab_n_q <= '0;
      sv_q    <= 1'b0;
      found_q <= 1'b0;
      rd_ok_q <= 1'b0;
      idx_q   <= '0;
      step_q  <= '0;
      eidx_q  <= '0;
    end else begin
      st_q    <= st_d;
      lab_n_q <= lab_n_d;
      sv_q    <= sv_d;
      found_q <= found_d;
      rd_ok_q <= rd_ok_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      eidx_q  <= eidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q <= sidx_d;
    pick_q <= pick_d;
    pdeg_q <= pdeg_d;
    best_q <= best_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    tgt_q  <= tgt_d;
    la_q   <= la_d;
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[node_wa] <= deg_wd;
    if (lab_we) lab_mem[node_wa] <= lab_wd;
    deg_rd_q <= deg_mem[node_ra];
    lab_rd_q <= lab_mem[node_ra];
  end
endmodule

// ===== sv/graph_degeneracy_ordering_core.sv =====
// ----------------------------------------------------------------------------
// graph_degeneracy_ordering_core
// Smallest-last degeneracy ordering over a stored edge list.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        words
//   in_i      in   valid/ready      opcode, first_node, second_node
//   out_o     out  valid/ready      value, error
//   cfg       in   cfg_we_i         node_count (cfg_wdata_i)
//
// An add, a spare opcode or a range error enters the waiting slot at the accept
// edge and moves on to the output register once that register is free.
// A label read first passes the label memory port and a read-wait state.
// Compute: clear the node memories, count degrees over the stored edges, then per
// peel step scan the nodes, pick one and pass over the edges to lower degrees, then
// clear the degrees and pass over the edges once more to count back edges.
// Reset zeroes the edge count and the labelled-node count; no sweep.
// Input stalls while the engine runs or the waiting slot is full; the waiting
// slot holds while the output register is full and out_o.ready is low.
// ----------------------------------------------------------------------------
module graph_degeneracy_ordering_core #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gdo_pkg::CFG_W-1:0]  cfg_wdata_i,
  gdo_in_if.sink                     in_i,
  gdo_out_if.source                  out_o
);
  import gdo_pkg::*;

  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES+1);

  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_eff;

  logic             busy_q, busy_d;
  logic             res_valid_q, res_valid_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  logic [ERR_W-1:0] res_err_q, res_err_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic [ERR_W-1:0] out_err_q, out_err_d;

  logic             acc, p_ok, q_ok, full, imm, res_load, out_free;
  logic [ERR_W-1:0] imm_err;
  logic             edge_we, edge_clear;
  logic [EAW-1:0]   edge_ra;
  logic [NODE_W-1:0] edge_a, edge_b;
  logic [ECW-1:0]   edge_cnt;

  gdo_cmd_t cmd;
  gdo_rsp_t rsp;

  // Hold the node count; cap it at the node memory depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign n_eff = (32'(cfg_q) > MAX_NODES) ? CFG_W'(MAX_NODES) : cfg_q;

  // Accept only with the engine free and the waiting slot empty.
  assign in_i.ready = !busy_q && !res_valid_q;
  assign acc        = in_i.valid && in_i.ready;

  assign p_ok = CFG_W'(in_i.first_node) < n_eff;
  assign q_ok = CFG_W'(in_i.second_node) < n_eff;
  assign full = edge_cnt == ECW'(MAX_EDGES);

  always_comb begin
    cmd         = '0;
    cmd.node    = in_i.first_node;
    cmd.compute = acc && (in_i.opcode == OP_COMPUTE);
    cmd.read    = acc && (in_i.opcode == OP_READ) && p_ok;
    edge_we     = acc && (in_i.opcode == OP_ADD) && p_ok && q_ok && !full;
    imm         = acc && !cmd.compute && !cmd.read;
    // the range check wins over the full store
    case (in_i.opcode)
      OP_ADD:  imm_err = !(p_ok && q_ok) ? ERR_RANGE : (full ? ERR_FULL : ERR_OK);
      OP_READ: imm_err = p_ok ? ERR_OK : ERR_RANGE;
      default: imm_err = ERR_OK;
    endcase
  end

  // Result flow: immediate or engine word -> waiting slot -> output register.
  assign res_load = imm || rsp.done;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    busy_d      = busy_q;
    res_valid_d = res_valid_q;
    res_val_d   = res_val_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;
    if (cmd.compute || cmd.read) busy_d = 1'b1;
    if (rsp.done) busy_d = 1'b0;
    if (out_o.ready) out_valid_d = 1'b0;
    if (res_valid_q && out_free) begin
      out_valid_d = 1'b1;
      out_val_d   = res_val_q;
      out_err_d   = res_err_q;
      res_valid_d = 1'b0;
    end
    if (res_load) begin
      res_valid_d = 1'b1;
      res_val_d   = rsp.done ? rsp.value : '0;
      res_err_d   = rsp.done ? ERR_OK : imm_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_val_q;
  assign out_o.error = out_err_q;

  gdo_edge_store #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edges (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (edge_we),
    .wr_a_i    (in_i.first_node),
    .wr_b_i    (in_i.second_node),
    .clear_i   (edge_clear),
    .rd_addr_i (edge_ra),
    .rd_a_o    (edge_a),
    .rd_b_o    (edge_b),
    .count_o   (edge_cnt)
  );

  gdo_node_engine #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .n_i          (n_eff),
    .rsp_o        (rsp),
    .edge_clear_o (edge_clear),
    .edge_ra_o    (edge_ra),
    .edge_a_i     (edge_a),
    .edge_b_i     (edge_b),
    .edge_cnt_i   (edge_cnt)
  );

  `include "graph_degeneracy_ordering_core_macros.svh"

  `GDO_NEVER(a_done_idle, rsp.done && !busy_q, "engine word without a command")
  `GDO_NEVER(a_res_ovf, res_valid_q && res_load, "waiting slot overwritten")
  `GDO_ASSERT(a_cnt_max, edge_cnt <= ECW'(MAX_EDGES), "edge count past store depth")
  `GDO_ASSERT(a_start, cmd.compute |=> busy_q, "compute did not start")
endmodule

// ===== dv/tb_graph_degeneracy_ordering_core.sv =====
// ----------------------------------------------------------------------------
// tb_graph_degeneracy_ordering_core
// Drives edge loads, peel computations and label reads into the core and
// checks every result word against a smallest-last peeling predictor.
// ----------------------------------------------------------------------------
module tb_graph_degeneracy_ordering_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gdo_pkg::*;

  localparam int unsigned NODE_LIMIT = 1024;
  localparam int unsigned EDGE_LIMIT = 4096;
  localparam int unsigned IDLE_LIMIT = 400000;
  localparam int unsigned RAND_WORDS = 1650;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // undecoded opcode, must be a no-op

  // Predictor of the peeling core plus the queue of expected result words.
  class peel_board;
    int unsigned node_count = 1;
    logic [NODE_W-1:0] edge_a[$];
    logic [NODE_W-1:0] edge_b[$];
    int unsigned degree[NODE_LIMIT];
    int unsigned label[NODE_LIMIT];
    logic [VAL_W-1:0] exp_value[$];
    gdo_err_e exp_error[$];
    int unsigned failures = 0;

    function int unsigned live_nodes();
      return (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
    endfunction

    function logic [VAL_W-1:0] peel();
      int unsigned n;
      int unsigned pick;
      int unsigned best;
      int unsigned a;
      int unsigned b;
      bit found;
      n = live_nodes();
      foreach (label[i]) label[i] = 0;
      for (int i = 0; i < n; i++) degree[i] = 0;
      foreach (edge_a[e]) begin
        a = edge_a[e];
        b = edge_b[e];
        if (a < n && b < n) begin
          degree[a]++;
          degree[b]++;
        end
      end
      // take the least-degree unlabelled node, lowest index wins a tie
      for (int s = 0; s < n; s++) begin
        found = 0;
        pick = 0;
        for (int i = 0; i < n; i++) begin
          if (label[i] == 0 && (!found || degree[i] < degree[pick])) begin
            pick = i;
            found = 1;
          end
        end
        if (!found) break;
        label[pick] = n - s;
        foreach (edge_a[e]) begin
          a = edge_a[e];
          b = edge_b[e];
          if (a < n && b < n) begin
            if (a == pick && label[b] == 0 && degree[b] > 0) degree[b]--;
            if (b == pick && label[a] == 0 && degree[a] > 0) degree[a]--;
          end
        end
      end
      for (int i = 0; i < n; i++) degree[i] = 0;
      foreach (edge_a[e]) begin
        a = edge_a[e];
        b = edge_b[e];
        if (a < n && b < n && a != b) begin
          if (label[b] < label[a]) degree[a]++;
          else if (label[a] < label[b]) degree[b]++;
        end
      end
      best = 0;
      for (int i = 0; i < n; i++) if (degree[i] > best) best = degree[i];
      edge_a.delete();
      edge_b.delete();
      return (best > 8191) ? VALUE_MAX : best[VAL_W-1:0];
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [NODE_W-1:0] p,
                            logic [NODE_W-1:0] q);
      logic [VAL_W-1:0] v;
      gdo_err_e err;
      int unsigned n;
      v = '0;
      err = ERR_OK;
      n = live_nodes();
      case (op)
        OP_ADD: begin
          if (p >= n || q >= n) err = ERR_RANGE;
          else if (edge_a.size() >= EDGE_LIMIT) err = ERR_FULL;
          else begin
            edge_a = {edge_a, p};
            edge_b = {edge_b, q};
          end
        end
        OP_COMPUTE: v = peel();
        OP_READ: begin
          if (p >= n) err = ERR_RANGE;
          else v = label[p][VAL_W-1:0];
        end
        default: ;
      endcase
      exp_value = {exp_value, v};
      exp_error = {exp_error, err};
    endfunction

    function void check_word(logic [VAL_W-1:0] v, logic [ERR_W-1:0] err);
      logic [VAL_W-1:0] ev;
      gdo_err_e ee;
      if (exp_value.size() == 0) begin
        $error("result word with nothing expected: value %0d error %0d", v, err);
        failures++;
        return;
      end
      ev = exp_value.pop_front();
      ee = exp_error.pop_front();
      if (v !== ev) begin
        $error("value: expected %0d, got %0d", ev, v);
        failures++;
      end
      if (err !== ee) begin
        $error("error: expected %0d, got %0d", ee, err);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return exp_value.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  int unsigned snd_idle = 30;
  int unsigned rcv_idle = 81;
  int unsigned idle_cycles = 0;
  int unsigned rand_sent = 0;
  peel_board sb = new();

  gdo_in_if in_if();
  gdo_out_if out_if();

  graph_degeneracy_ordering_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_ADD;
    in_if.first_node = '0;
    in_if.second_node = '0;
  end

  // Result side: check each accepted word, then stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_word(out_if.value, out_if.error);
      out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one word; hold it until accepted, note it at the accepting edge.
  // Valid stays high on return; the next call or the caller drops it.
  task automatic send_word(logic [OP_W-1:0] op, int unsigned p, int unsigned q);
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.first_node <= p[NODE_W-1:0];
    in_if.second_node <= q[NODE_W-1:0];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(op, p[NODE_W-1:0], q[NODE_W-1:0]);
  endtask

  // Write node_count only once the core has drained.
  task automatic write_count(int unsigned n);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.node_count = n;
  endtask

  task automatic random_round();
    int unsigned n;
    int unsigned eff;
    int unsigned words;
    int unsigned r;
    r = $urandom_range(19);
    case (r)
      0: n = 0;
      1: n = 1;
      2: n = 1024;
      3: n = 2047;
      4: n = $urandom_range(2047);
      default: n = $urandom_range(12, 2);
    endcase
    write_count(n);
    eff = (n > NODE_LIMIT) ? NODE_LIMIT : n;
    words = $urandom_range(30, 5);
    for (int k = 0; k < words; k++) begin
      // pick the idling mix from how far the random part has got
      if (rand_sent < RAND_WORDS / 3) begin
        snd_idle = 30; rcv_idle = 81;
      end else if (rand_sent < 2 * RAND_WORDS / 3) begin
        snd_idle = 81; rcv_idle = 30;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      r = $urandom_range(99);
      if (r < 70 && eff > 0)
        send_word(OP_ADD, $urandom_range(eff - 1), $urandom_range(eff - 1));
      else if (r < 78)
        send_word(OP_ADD, $urandom(), $urandom());
      else if (r < 90)
        send_word(OP_READ, (eff > 0 && r < 86) ? $urandom_range(eff - 1) : $urandom(),
                  $urandom());
      else if (r < 93)
        send_word(OP_SPARE, $urandom(), $urandom());
      else if (eff <= 40)
        send_word(OP_COMPUTE, $urandom(), $urandom());
      else
        send_word(OP_READ, $urandom(), $urandom());
      rand_sent++;
    end
    // close small graphs with a peel and a few label reads
    if (eff <= 40) begin
      send_word(OP_COMPUTE, $urandom(), $urandom());
      rand_sent++;
      for (int k = 0; k < 3 && eff > 0; k++) begin
        send_word(OP_READ, $urandom_range(eff - 1), $urandom());
        rand_sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single node: unlabelled read, range errors, self-loop, spare opcode
    send_word(OP_READ, 0, 0);
    send_word(OP_READ, 1, 0);
    send_word(OP_ADD, 0, 0);
    send_word(OP_ADD, 0, 1);
    send_word(OP_SPARE, 1023, 1023);
    send_word(OP_COMPUTE, 0, 0);
    send_word(OP_READ, 0, 0);

    // four nodes with a repeated edge and a self-loop
    write_count(4);
    send_word(OP_ADD, 0, 1);
    send_word(OP_ADD, 1, 1);
    send_word(OP_ADD, 1, 2);
    send_word(OP_ADD, 2, 3);
    send_word(OP_ADD, 3, 0);
    send_word(OP_ADD, 0, 1);
    send_word(OP_ADD, 1023, 0);
    send_word(OP_COMPUTE, 0, 0);
    for (int i = 0; i < 4; i++) send_word(OP_READ, i, 0);
    send_word(OP_READ, 1023, 0);

    // count above the node limit caps; then lower it so the top edge drops out
    write_count(2047);
    send_word(OP_ADD, 1023, 1023);
    send_word(OP_READ, 1023, 0);
    send_word(OP_ADD, 1023, 0);
    write_count(3);
    send_word(OP_ADD, 0, 2);
    send_word(OP_COMPUTE, 0, 0);
    send_word(OP_READ, 2, 0);

    // no nodes at all
    write_count(0);
    send_word(OP_COMPUTE, 0, 0);
    send_word(OP_READ, 0, 0);
    send_word(OP_ADD, 0, 0);

    // two nodes: one endpoint out of range, then a plain edge
    write_count(2);
    send_word(OP_ADD, 0, 5);
    send_word(OP_ADD, 0, 1);
    send_word(OP_COMPUTE, 0, 0);
    send_word(OP_READ, 1, 0);

    while (rand_sent < RAND_WORDS) random_round();

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
